@@ src/xrr_pkg.sv @@
// Shared types and constants for the ranged xorshift128 random block.
`default_nettype none

package xrr_pkg;

  // Data word width
  localparam int unsigned WORD_W = 32;

  // Generator seeds loaded at reset
  localparam logic [WORD_W-1:0] SEED_A = 32'd123456789;
  localparam logic [WORD_W-1:0] SEED_B = 32'd362436069;
  localparam logic [WORD_W-1:0] SEED_C = 32'd521288629;
  localparam logic [WORD_W-1:0] SEED_D = 32'd88675123;

  // xorshift128 shift amounts
  localparam int unsigned SHIFT_T_LEFT  = 11;
  localparam int unsigned SHIFT_D_RIGHT = 19;
  localparam int unsigned SHIFT_T_RIGHT = 8;

  // Remainder unit step count
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } xrr_state_t;

  // Control into the remainder unit
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // Status out of the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

@@ src/xrr_if.sv @@
// Request and result channel interfaces for the ranged random block.
`default_nettype none

interface xrr_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [xrr_pkg::WORD_W-1:0] lower_bound;
  logic signed [xrr_pkg::WORD_W-1:0] upper_bound;

  modport source (output valid, output lower_bound, output upper_bound, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

interface xrr_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [xrr_pkg::WORD_W-1:0] ranged_value;
  logic        [xrr_pkg::WORD_W-1:0] raw_word;

  modport source (output valid, output ranged_value, output raw_word, input ready);
  modport sink   (input valid, input ranged_value, input raw_word, output ready);
endinterface

`default_nettype wire

@@ src/xorshift128_ranged_random.sv @@
// Top level: xorshift128 generator with per-request range reduction.
// Flow: an accepted request runs the bit-serial remainder unit, one restoring step per
//   dividend bit, then the lower bound is added into the output register.
// Requests are taken only while idle, so none is accepted while the remainder unit
//   runs; a result still waiting when the next one completes holds off new requests.
// Reset: synchronous active-low; generator words return to their seeds and
//   both channels go idle.
`default_nettype none

module xorshift128_ranged_random (
  input  logic             clk,
  input  logic             rst_n,
  xrr_in_if.sink           in_ch,
  xrr_out_if.source        out_ch
);

  localparam int unsigned W = xrr_pkg::WORD_W;

  xrr_pkg::xrr_state_t state_r;
  xrr_pkg::xrr_state_t state_nxt;

  // Generator words
  logic [W-1:0] gen_a_r, gen_b_r, gen_c_r, gen_d_r;

  // Per-request working registers
  logic [W-1:0] raw_r;
  logic [W-1:0] lo_r;
  logic [W-1:0] span_r;

  // Output register
  logic         out_valid_r;
  logic [W-1:0] out_value_r;
  logic [W-1:0] out_raw_r;

  logic         in_fire;
  logic         slot_free;
  logic         load_out;
  logic [W-1:0] gen_t;
  logic [W-1:0] gen_new;
  logic [W-1:0] span_new;
  logic [W-1:0] offset;
  logic [W-1:0] rem;

  xrr_pkg::div_ctl_t div_ctl;
  xrr_pkg::div_sts_t div_sts;

  // Generator step and span
  always_comb begin
    gen_t    = gen_a_r ^ (gen_a_r << xrr_pkg::SHIFT_T_LEFT);
    gen_new  = (gen_d_r ^ (gen_d_r >> xrr_pkg::SHIFT_D_RIGHT))
             ^ (gen_t ^ (gen_t >> xrr_pkg::SHIFT_T_RIGHT));
    span_new = W'(in_ch.upper_bound) - W'(in_ch.lower_bound) + W'(1);
  end

  // Handshake
  assign in_ch.ready = (state_r == xrr_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign div_ctl.start = in_fire;

  // Remainder unit
  xrr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (gen_new),
    .divisor   (span_new),
    .sts       (div_sts),
    .remainder (rem)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      xrr_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = xrr_pkg::ST_DIV;
        end
      end
      xrr_pkg::ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = slot_free ? xrr_pkg::ST_IDLE : xrr_pkg::ST_OUT;
        end
      end
      xrr_pkg::ST_OUT: begin
        if (slot_free) begin
          state_nxt = xrr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = xrr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    load_out = 1'b0;
    unique case (state_r)
      xrr_pkg::ST_IDLE: load_out = 1'b0;
      xrr_pkg::ST_DIV:  load_out = div_sts.done && slot_free;
      xrr_pkg::ST_OUT:  load_out = slot_free;
      default:          load_out = 1'b0;
    endcase
  end

  // Full range span takes the raw word unreduced
  assign offset = (span_r == '0) ? raw_r : rem;

  // Control registers and generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xrr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      gen_a_r     <= xrr_pkg::SEED_A;
      gen_b_r     <= xrr_pkg::SEED_B;
      gen_c_r     <= xrr_pkg::SEED_C;
      gen_d_r     <= xrr_pkg::SEED_D;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        gen_a_r <= gen_b_r;
        gen_b_r <= gen_c_r;
        gen_c_r <= gen_d_r;
        gen_d_r <= gen_new;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      raw_r  <= gen_new;
      lo_r   <= W'(in_ch.lower_bound);
      span_r <= span_new;
    end
    if (load_out) begin
      out_value_r <= offset + lo_r;
      out_raw_r   <= raw_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.ranged_value = out_value_r;
  assign out_ch.raw_word     = out_raw_r;

  // A new remainder run never starts over one in progress
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("remainder unit restarted while busy");

  // Remainder completion only arrives while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == xrr_pkg::ST_DIV))
    else $error("remainder done outside divide state");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ch.ready))
    else $error("output register overwritten");

  // Full range result is raw word plus lower bound
  a_full_range: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && span_r == '0) |=> (out_value_r == $past(raw_r) + $past(lo_r)))
    else $error("full range result mismatch");

endmodule

`default_nettype wire

@@ src/xrr_div.sv @@
// Bit-serial restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module xrr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  xrr_pkg::div_ctl_t          ctl,
  input  logic [xrr_pkg::WORD_W-1:0] dividend,
  input  logic [xrr_pkg::WORD_W-1:0] divisor,
  output xrr_pkg::div_sts_t          sts,
  output logic [xrr_pkg::WORD_W-1:0] remainder
);

  localparam int unsigned W = xrr_pkg::WORD_W;

  logic                          busy_r;
  logic                          done_r;
  logic [xrr_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [W-1:0]                  dvd_r;
  logic [W-1:0]                  dsr_r;
  logic [W:0]                    rem_r;

  logic [W:0] rem_sh;
  logic [W:0] rem_nxt;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_r[W-1:0], dvd_r[W-1]};
    if (rem_sh >= {1'b0, dsr_r}) begin
      rem_nxt = rem_sh - {1'b0, dsr_r};
    end else begin
      rem_nxt = rem_sh;
    end
  end

  // Step counter and status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == xrr_pkg::DIV_CNT_W'(xrr_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers; remainder holds after done
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign remainder = rem_r[W-1:0];

endmodule

`default_nettype wire

@@ tb/xrr_draw_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the ranged random block: predicts every draw and compares results.
module xrr_draw_checker (
  input  logic        clk,
  input  logic        rst_n,
  xrr_in_if           in_mon,
  xrr_out_if          out_mon,
  output int unsigned fail_cnt,
  output int unsigned pending_cnt
);

  typedef struct packed {
    logic [xrr_pkg::WORD_W-1:0] ranged_value;
    logic [xrr_pkg::WORD_W-1:0] raw_word;
  } draw_t;

  // Private copy of the generator words
  logic [xrr_pkg::WORD_W-1:0] xs_a;
  logic [xrr_pkg::WORD_W-1:0] xs_b;
  logic [xrr_pkg::WORD_W-1:0] xs_c;
  logic [xrr_pkg::WORD_W-1:0] xs_d;

  // Draws predicted for accepted requests, oldest first
  draw_t       pending_draws [$];
  int unsigned result_idx;

  // One xorshift128 step; returns the new word
  function automatic logic [xrr_pkg::WORD_W-1:0] next_word();
    logic [xrr_pkg::WORD_W-1:0] t;
    t    = xs_a ^ (xs_a << xrr_pkg::SHIFT_T_LEFT);
    xs_a = xs_b;
    xs_b = xs_c;
    xs_c = xs_d;
    xs_d = (xs_d ^ (xs_d >> xrr_pkg::SHIFT_D_RIGHT)) ^ (t ^ (t >> xrr_pkg::SHIFT_T_RIGHT));
    return xs_d;
  endfunction

  // Span wraps mod 2^32; a zero span means the full range, no reduction
  function automatic draw_t predict_draw(logic [xrr_pkg::WORD_W-1:0] lo,
                                         logic [xrr_pkg::WORD_W-1:0] hi);
    logic [xrr_pkg::WORD_W-1:0] span;
    draw_t                      d;
    span           = hi - lo + 1'b1;
    d.raw_word     = next_word();
    d.ranged_value = ((span == '0) ? d.raw_word : (d.raw_word % span)) + lo;
    return d;
  endfunction

  task automatic report_mismatch(string what, logic [xrr_pkg::WORD_W-1:0] got,
                                 logic [xrr_pkg::WORD_W-1:0] exp_v);
    $display("result %0d: %s got %h, expected %h", result_idx, what, got, exp_v);
    fail_cnt++;
  endtask

  always @(posedge clk) begin : track
    draw_t exp_d;
    if (!rst_n) begin
      xs_a = xrr_pkg::SEED_A;
      xs_b = xrr_pkg::SEED_B;
      xs_c = xrr_pkg::SEED_C;
      xs_d = xrr_pkg::SEED_D;
      pending_draws.delete();
      result_idx = 0;
    end else begin
      // results first, so a request taken this cycle can never cover a result
      if (out_mon.valid && out_mon.ready) begin
        if (pending_draws.size() == 0) begin
          report_mismatch("result with no request, raw_word", out_mon.raw_word, '0);
        end else begin
          exp_d = pending_draws.pop_front();
          if (out_mon.ranged_value !== exp_d.ranged_value) begin
            report_mismatch("ranged_value", out_mon.ranged_value, exp_d.ranged_value);
          end
          if (out_mon.raw_word !== exp_d.raw_word) begin
            report_mismatch("raw_word", out_mon.raw_word, exp_d.raw_word);
          end
        end
        result_idx++;
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_draws.push_back(predict_draw(in_mon.lower_bound, in_mon.upper_bound));
      end
    end
    pending_cnt <= pending_draws.size();
  end

endmodule

@@ tb/tb_xorshift128_ranged_random.sv @@
`timescale 1ns / 100ps
// Testbench top for the ranged random block: request stimulus, result stalls and verdict.
module tb_xorshift128_ranged_random;

  localparam int unsigned RANDOM_ITEMS = 1630;
  localparam int unsigned CALM_TAIL    = 250;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_ITEMS   = 16;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam longint     WATCHDOG_NS  = 64'd10_000_000;

  localparam logic [xrr_pkg::WORD_W-1:0] W_MIN  = 32'h8000_0000;
  localparam logic [xrr_pkg::WORD_W-1:0] W_MAX  = 32'h7FFF_FFFF;
  localparam logic [xrr_pkg::WORD_W-1:0] W_NEG1 = 32'hFFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        tx_idle_en;
  logic        rx_idle_en;
  logic        rx_hold_req;
  int unsigned fail_cnt;
  int unsigned pending_cnt;

  xrr_in_if  in_ch ();
  xrr_out_if out_ch ();

  xorshift128_ranged_random u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  xrr_draw_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  initial begin
    #(WATCHDOG_NS);
    $display("FAILURE");
    $finish;
  end

  // Offer one request, with an optional idle burst ahead of it
  task automatic send_request(input logic [xrr_pkg::WORD_W-1:0] lo,
                              input logic [xrr_pkg::WORD_W-1:0] hi);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid       <= 1'b0;
      in_ch.lower_bound <= $urandom;
      in_ch.upper_bound <= $urandom;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.lower_bound <= lo;
    in_ch.upper_bound <= hi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted draw has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_cnt == 0);
  endtask

  function automatic logic [xrr_pkg::WORD_W-1:0] extreme_bound();
    case ($urandom_range(0, 3))
      0:       return W_MIN;
      1:       return W_MAX;
      2:       return '0;
      default: return W_NEG1;
    endcase
  endfunction

  // Small spans most often, plus random, full range, wrapped, extreme and power-of-two spans
  task automatic pick_bounds(output logic [xrr_pkg::WORD_W-1:0] lo,
                             output logic [xrr_pkg::WORD_W-1:0] hi);
    logic [xrr_pkg::WORD_W-1:0] span;
    lo = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        span = $urandom_range(1, 64);
        hi   = lo + span - 1'b1;
      end
      4:       hi = $urandom;
      5:       hi = lo - 1'b1;
      6:       hi = lo - $urandom_range(1, 1000);
      7: begin
        lo = extreme_bound();
        hi = extreme_bound();
      end
      default: begin
        span = 32'd1 << $urandom_range(0, 31);
        hi   = lo + span - 1'b1;
      end
    endcase
  endtask

  // Result side: random stall bursts, plus one long hold on request
  initial begin : receiver
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Request side and verdict
  initial begin : stimulus
    logic [xrr_pkg::WORD_W-1:0] lo;
    logic [xrr_pkg::WORD_W-1:0] hi;
    int unsigned                tail_start;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    rx_hold_req = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.lower_bound <= '0;
    in_ch.upper_bound <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full range: span wraps to zero
    send_request(W_MIN, W_MAX);
    send_request('0, W_NEG1);
    send_request(32'd1, '0);
    // widest nonzero span
    send_request(W_MIN, W_MAX - 1'b1);
    // single-value ranges at the extremes
    send_request('0, '0);
    send_request(W_MAX, W_MAX);
    send_request(W_MIN, W_MIN);
    send_request(W_NEG1, W_NEG1);
    // upper below lower (the last pair only as unsigned values)
    send_request(W_MAX, W_MIN);
    send_request(32'd100, -32'd100);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
    // negative bounds, and signed bounds on either side of zero
    send_request(-32'd5, 32'd5);
    send_request(-32'd1000, W_NEG1);
    send_request(W_NEG1, '0);
    // half-range, small odd and near one-third-range spans
    send_request('0, W_MAX);
    send_request(W_MIN, W_NEG1);
    send_request(W_MAX, 32'hFFFF_FFFE);
    send_request('0, 32'd2);
    send_request(32'd10, 32'd16);
    send_request(32'h5555_5555, 32'hAAAA_AAAA);

    // sender pause until everything is back
    drain_results();

    // long result stall while requests keep coming: block fills and backs up
    rx_hold_req = 1'b1;
    tx_idle_en  = 1'b0;
    for (int i = 0; i < HOLD_ITEMS; i++) begin
      pick_bounds(lo, hi);
      send_request(lo, hi);
    end

    // random part; one calm stretch in the middle, calm tail at the end
    tail_start = RANDOM_ITEMS - CALM_TAIL;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      tx_idle_en = !((i >= 600 && i < 700) || i >= tail_start);
      rx_idle_en = !((i >= 650 && i < 750) || i >= tail_start);
      pick_bounds(lo, hi);
      send_request(lo, hi);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/xrr_pkg.sv
src/xrr_if.sv
src/xrr_div.sv
src/xorshift128_ranged_random.sv
tb/xrr_draw_checker.sv
tb/tb_xorshift128_ranged_random.sv
